### sv/fragment_blob_staging_buffer_top_defines.svh
// assertion macros for the fragment blob staging buffer
`ifndef FRAGMENT_BLOB_STAGING_BUFFER_TOP_DEFINES_SVH
`define FRAGMENT_BLOB_STAGING_BUFFER_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define FBSB_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define FBSB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/fbsb_pkg.sv
// shared types and constants of the fragment blob staging buffer
`default_nettype none

package fbsb_pkg;

   localparam int BLOB_BYTES_DEF = 1024;
   localparam int LANES          = 8;
   localparam int REQ_DATA_W     = 112;
   localparam int RSP_DATA_W     = 128;

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_HEADER = 2'd1;
   localparam logic [1:0] OP_DATA   = 2'd2;
   localparam logic [1:0] OP_READ   = 2'd3;

   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_INVALID  = 3'd1;
   localparam logic [2:0] ERR_OVERFLOW = 3'd2;
   localparam logic [2:0] ERR_ORDER    = 3'd3;
   localparam logic [2:0] ERR_NO_BLOB  = 3'd4;

   localparam logic [1:0] PH_EMPTY     = 2'd0;
   localparam logic [1:0] PH_RECEIVING = 2'd1;
   localparam logic [1:0] PH_READY     = 2'd2;

   typedef struct packed {
      logic load;
      logic exec;
      logic rd_issue;
      logic rd_emit;
   } fbsb_cmd_type;

   typedef struct packed {
      logic out_free;
      logic read_go;
      logic read_last;
   } fbsb_sts_type;

endpackage

`default_nettype wire

### sv/fbsb_ctrl.sv
// sequencer for request capture, execution and read word emission
`default_nettype none

module fbsb_ctrl import fbsb_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire fbsb_sts_type sts,
   output fbsb_cmd_type      cmd
);

   localparam logic [1:0] S_IDLE     = 2'd0;
   localparam logic [1:0] S_EXEC     = 2'd1;
   localparam logic [1:0] S_RD_ISSUE = 2'd2;
   localparam logic [1:0] S_RD_EMIT  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (sts.out_free) begin
               cmd.exec = 1'b1;
               state_in = sts.read_go ? S_RD_ISSUE : S_IDLE;
            end
         end
         S_RD_ISSUE: begin
            cmd.rd_issue = 1'b1;
            state_in     = S_RD_EMIT;
         end
         S_RD_EMIT: begin
            if (sts.out_free) begin
               cmd.rd_emit = 1'b1;
               state_in    = sts.read_last ? S_IDLE : S_RD_ISSUE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### sv/fbsb_datapath.sv
// request registers, blob state, banked byte store and result register
`default_nettype none

module fbsb_datapath import fbsb_pkg::*; #(
   parameter int BLOB_BYTES = BLOB_BYTES_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire fbsb_cmd_type          cmd,
   output fbsb_sts_type               sts,
   input  wire logic [1:0]            req_tuser,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tlast,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tlast
);

   localparam int BANK_DEPTH = (BLOB_BYTES + LANES - 1) / LANES;
   localparam int ROW_W      = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

   // captured request
   logic [1:0]  op_ff;
   logic [7:0]  tag_ff;
   logic [15:0] off_ff;
   logic [7:0]  len_ff;
   logic        fin_ff;
   logic [63:0] word_ff;
   logic [3:0]  cnt_ff;
   logic [7:0]  cap_ff;

   // blob state
   logic [15:0] committed_ff, committed_in;
   logic [7:0]  cur_tx_ff, cur_tx_in;
   logic        complete_ff, complete_in;
   logic [1:0]  phase_ff, phase_in;
   logic [2:0]  err_ff, err_in;
   logic [31:0] gen_ff, gen_in;
   logic        active_ff, active_in;
   logic [7:0]  remaining_ff, remaining_in;
   logic        final_ff, final_in;
   logic [15:0] wp_ff, wp_in;
   logic [15:0] pos_ff, pos_in;
   logic [7:0]  avail_ff, avail_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [7:0] rdata_ff [LANES];

   logic        ovf;
   logic [3:0]  cnt_clamp;
   logic [3:0]  n_wr;
   logic [15:0] wp_next;
   logic [7:0]  rem_next;
   logic        read_ok;
   logic [15:0] span;
   logic [7:0]  avail_start;
   logic [3:0]  n_rd;
   logic [63:0] rd_word;
   logic [2:0]  rot_idx;
   logic [2:0]  inc;
   logic        res_ok;
   logic [2:0]  res_err;
   logic        load_op;
   logic        load_rd;
   logic        wr_go;

   assign ovf       = ({1'b0, off_ff} + 17'(len_ff)) > 17'(BLOB_BYTES);
   assign cnt_clamp = (cnt_ff > 4'd8) ? 4'd8 : cnt_ff;
   assign n_wr      = (8'(cnt_clamp) > remaining_ff) ? remaining_ff[3:0] : cnt_clamp;
   assign wp_next   = wp_ff + 16'(n_wr);
   assign rem_next  = remaining_ff - 8'(n_wr);
   assign read_ok   = complete_ff && (tag_ff == cur_tx_ff) && (off_ff <= committed_ff);
   assign span      = committed_ff - off_ff;
   assign avail_start = (span > 16'(cap_ff)) ? cap_ff : span[7:0];
   assign n_rd      = (avail_ff > 8'd8) ? 4'd8 : avail_ff[3:0];

   assign sts.read_go   = (op_ff == OP_READ) && read_ok;
   assign sts.read_last = (avail_ff <= 8'd8);
   assign sts.out_free  = !rsp_valid_ff || rsp_tready;

   assign wr_go = cmd.exec && (op_ff == OP_DATA) && active_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_tuser;
         tag_ff  <= req_tdata[7:0];
         off_ff  <= req_tdata[23:8];
         len_ff  <= req_tdata[31:24];
         fin_ff  <= req_tlast;
         word_ff <= req_tdata[95:32];
         cnt_ff  <= req_tdata[99:96];
         cap_ff  <= req_tdata[107:100];
      end
   end

   // byte banks, lane b holds the bytes whose address is b modulo eight
   for (genvar b = 0; b < LANES; b++) begin : g_bank
      logic [7:0]       bank_mem [BANK_DEPTH];
      logic [2:0]       wr_lane;
      logic [16:0]      wr_addr;
      logic             wr_en;
      logic [2:0]       rd_lane;
      logic [16:0]      rd_addr;
      logic [ROW_W-1:0] wr_row;
      logic [ROW_W-1:0] rd_row;

      assign wr_lane = 3'(b) - wp_ff[2:0];
      assign wr_addr = {1'b0, wp_ff} + 17'(wr_lane);
      assign wr_en   = wr_go && (4'(wr_lane) < n_wr) && (wr_addr < 17'(BLOB_BYTES));
      assign wr_row  = wr_addr[ROW_W+2:3];
      assign rd_lane = 3'(b) - pos_ff[2:0];
      assign rd_addr = {1'b0, pos_ff} + 17'(rd_lane);
      assign rd_row  = rd_addr[ROW_W+2:3];

      always_ff @(posedge clock) begin
         if (wr_en) begin
            bank_mem[wr_row] <= word_ff[8*wr_lane +: 8];
         end
         if (cmd.rd_issue) begin
            rdata_ff[b] <= bank_mem[rd_row];
         end
      end
   end

   always_comb begin
      rd_word = '0;
      rot_idx = '0;
      for (int k = 0; k < LANES; k++) begin
         rot_idx = pos_ff[2:0] + 3'(k);
         rd_word[8*k +: 8] = (4'(k) < n_rd) ? rdata_ff[rot_idx] : 8'h00;
      end
   end

   always_comb begin
      committed_in = committed_ff;
      cur_tx_in    = cur_tx_ff;
      complete_in  = complete_ff;
      phase_in     = phase_ff;
      err_in       = err_ff;
      active_in    = active_ff;
      remaining_in = remaining_ff;
      final_in     = final_ff;
      wp_in        = wp_ff;
      pos_in       = pos_ff;
      avail_in     = avail_ff;
      inc          = '0;
      res_ok       = 1'b0;
      res_err      = ERR_NONE;
      if (cmd.exec) begin
         case (op_ff)
            OP_CLEAR: begin
               committed_in = '0;
               cur_tx_in    = '0;
               complete_in  = 1'b0;
               active_in    = 1'b0;
               remaining_in = '0;
               final_in     = 1'b0;
               wp_in        = '0;
               if (err_ff != ERR_NONE) inc = inc + 3'd1;
               if (phase_ff != PH_EMPTY) inc = inc + 3'd1;
               inc      = inc + 3'd1;
               err_in   = ERR_NONE;
               phase_in = PH_EMPTY;
               res_ok   = 1'b1;
            end
            OP_HEADER: begin
               active_in = 1'b0;
               if (ovf) begin
                  res_err = ERR_OVERFLOW;
                  if (err_ff != ERR_OVERFLOW) inc = inc + 3'd1;
                  err_in = ERR_OVERFLOW;
               end else if (off_ff == 16'd0 ||
                            (tag_ff == cur_tx_ff && !complete_ff &&
                             off_ff == committed_ff)) begin
                  // offset zero restarts reception
                  if (off_ff == 16'd0) begin
                     cur_tx_in    = tag_ff;
                     committed_in = '0;
                     complete_in  = 1'b0;
                     if (err_ff != ERR_NONE) inc = inc + 3'd1;
                     err_in = ERR_NONE;
                     if (phase_ff != PH_RECEIVING) inc = inc + 3'd1;
                     phase_in = PH_RECEIVING;
                  end
                  res_ok       = 1'b1;
                  active_in    = 1'b1;
                  remaining_in = len_ff;
                  final_in     = fin_ff;
                  wp_in        = off_ff;
                  if (len_ff == 8'd0) begin
                     active_in    = 1'b0;
                     committed_in = off_ff;
                     if (fin_ff) begin
                        complete_in = 1'b1;
                        if (off_ff == 16'd0 || phase_ff != PH_READY) inc = inc + 3'd1;
                        phase_in = PH_READY;
                     end
                     inc = inc + 3'd1;
                  end
               end else begin
                  res_err = ERR_ORDER;
                  if (err_ff != ERR_ORDER) inc = inc + 3'd1;
                  err_in = ERR_ORDER;
               end
            end
            OP_DATA: begin
               if (active_ff) begin
                  res_ok       = 1'b1;
                  wp_in        = wp_next;
                  remaining_in = rem_next;
                  if (rem_next == 8'd0) begin
                     active_in    = 1'b0;
                     committed_in = wp_next;
                     if (final_ff) begin
                        complete_in = 1'b1;
                        if (phase_ff != PH_READY) inc = inc + 3'd1;
                        phase_in = PH_READY;
                     end
                     inc = inc + 3'd1;
                  end
               end else begin
                  res_err = ERR_INVALID;
                  if (err_ff != ERR_INVALID) inc = inc + 3'd1;
                  err_in = ERR_INVALID;
               end
            end
            OP_READ: begin
               if (!complete_ff) begin
                  res_err = ERR_NO_BLOB;
                  if (err_ff != ERR_NO_BLOB) inc = inc + 3'd1;
                  err_in = ERR_NO_BLOB;
               end else if (!read_ok) begin
                  res_err = ERR_INVALID;
                  if (err_ff != ERR_INVALID) inc = inc + 3'd1;
                  err_in = ERR_INVALID;
               end else begin
                  if (err_ff != ERR_NONE) inc = inc + 3'd1;
                  err_in   = ERR_NONE;
                  pos_in   = off_ff;
                  avail_in = avail_start;
               end
            end
            default: begin
               res_ok = 1'b0;
            end
         endcase
      end else if (cmd.rd_emit) begin
         pos_in   = pos_ff + 16'(n_rd);
         avail_in = avail_ff - 8'(n_rd);
      end
      gen_in = gen_ff + 32'(inc);
   end

   assign load_op = cmd.exec && !sts.read_go;
   assign load_rd = cmd.rd_emit;

   always_comb begin
      rsp_data_in = rsp_data_ff;
      rsp_last_in = rsp_last_ff;
      if (load_rd) begin
         rsp_data_in = {5'b0, n_rd, rd_word, complete_ff, committed_ff, gen_ff,
                        phase_ff, ERR_NONE, 1'b1};
         rsp_last_in = sts.read_last;
      end else if (load_op) begin
         rsp_data_in = {5'b0, 4'd0, 64'd0, complete_in, committed_in, gen_in,
                        phase_in, res_err, res_ok};
         rsp_last_in = 1'b1;
      end
      if (load_op || load_rd) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         committed_ff <= '0;
         cur_tx_ff    <= '0;
         complete_ff  <= 1'b0;
         phase_ff     <= PH_EMPTY;
         err_ff       <= ERR_NONE;
         gen_ff       <= 32'd1;
         active_ff    <= 1'b0;
         remaining_ff <= '0;
         final_ff     <= 1'b0;
         wp_ff        <= '0;
         pos_ff       <= '0;
         avail_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         committed_ff <= committed_in;
         cur_tx_ff    <= cur_tx_in;
         complete_ff  <= complete_in;
         phase_ff     <= phase_in;
         err_ff       <= err_in;
         gen_ff       <= gen_in;
         active_ff    <= active_in;
         remaining_ff <= remaining_in;
         final_ff     <= final_in;
         wp_ff        <= wp_in;
         pos_ff       <= pos_in;
         avail_ff     <= avail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

### sv/fragment_blob_staging_buffer_top.sv
// fragment blob staging buffer, top level
// a clear, header or data request is captured, then executed into the result register once that is free
// a new request is accepted only after the previous one is done; a read is captured and executed, then
// alternately fetches a word from the banked store and loads it into the result register once that is free
// reset: synchronous active high, clears control and blob state, store is not cleared
`default_nettype none
`include "fragment_blob_staging_buffer_top_defines.svh"

module fragment_blob_staging_buffer_top import fbsb_pkg::*; #(
   parameter int BLOB_BYTES = BLOB_BYTES_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // transaction_tag, byte_offset, fragment_length, data_word, data_count, read_capacity
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // operation
   input  wire logic [1:0]            req_tuser,
   // final_flag
   input  wire logic                  req_tlast,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // accepted, error_code, phase, generation_count, stored_length, blob_complete,
   // read_word, read_count
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // last_of_run
   output logic                       rsp_tlast
);

   fbsb_cmd_type cmd;
   fbsb_sts_type sts;

   fbsb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   fbsb_datapath #(
      .BLOB_BYTES (BLOB_BYTES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   `FBSB_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready, "ready after accept")
   `FBSB_ASSERT_NOW(a_reject_single, rsp_tvalid && !rsp_tdata[0], rsp_tlast, "rejected request not last")
   `FBSB_ASSERT_NOW(a_full_mid, rsp_tvalid && !rsp_tlast, rsp_tdata[122:119] == 4'd8, "short word")

endmodule

`default_nettype wire

### bench/tb_fragment_blob_staging_buffer_top.sv
// self-checking bench for the fragment blob staging buffer with its own blob predictor
module tb_fragment_blob_staging_buffer_top;
   import fbsb_pkg::*;

   localparam int RANDOM_REQUESTS = 136;
   localparam int CLOCK_HALF      = 6;
   localparam int CYCLE_LIMIT     = 1000000;
   localparam int MEM_AW          = $clog2(BLOB_BYTES_DEF);

   typedef struct {
      logic [1:0]  op;
      logic [7:0]  tag;
      logic [15:0] offset;
      logic [7:0]  frag_len;
      logic        fin;
      logic [63:0] word;
      logic [3:0]  count;
      logic [7:0]  cap;
   } frag_req_type;

   typedef struct {
      logic        ok;
      logic [2:0]  err;
      logic [1:0]  ph;
      logic [31:0] gen;
      logic [15:0] stored;
      logic        done;
      logic [63:0] word;
      logic [3:0]  count;
      logic        last;
   } blob_status_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // transaction_tag, byte_offset, fragment_length, data_word, data_count, read_capacity
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   // operation
   logic [1:0]            req_tuser = OP_CLEAR;
   // final_flag
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // accepted, error_code, phase, generation_count, stored_length, blob_complete,
   // read_word, read_count
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // last_of_run
   logic                  rsp_tlast;

   fragment_blob_staging_buffer_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   frag_req_type    request_backlog[$];
   blob_status_type status_due[$];
   int              requests_taken = 0;
   int              total_requests = 0;
   int              faults = 0;
   int              cycle_no = 0;
   int              send_gap = 0;
   int              stall_left = 0;

   // predicted blob state
   logic [7:0]  blob_mem [BLOB_BYTES_DEF];
   logic [15:0] stored_len = '0;
   logic [7:0]  cur_tag = '0;
   logic        complete = 1'b0;
   logic [1:0]  cur_phase = PH_EMPTY;
   logic [2:0]  last_err = ERR_NONE;
   logic [31:0] generation = 32'd1;
   logic        frag_open = 1'b0;
   logic [7:0]  frag_left = '0;
   logic        frag_final = 1'b0;
   logic [15:0] wr_ptr = '0;

   initial begin
      forever #CLOCK_HALF clock = ~clock;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #(2 * CLOCK_HALF * CYCLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   always @(posedge clock) cycle_no <= cycle_no + 1;

   // each side has its own window of steady traffic
   function automatic int pick_gap(input int lane, input int long_max);
      int roll;
      roll = $urandom_range(0, 99);
      if ((cycle_no / 300) % 3 == lane) return 0;
      if (roll < 70) return 0;
      if (roll < 96) return $urandom_range(1, 3);
      return $urandom_range(10, long_max);
   endfunction

   function automatic frag_req_type any_request();
      frag_req_type r;
      r.op       = 2'($urandom_range(0, 3));
      r.tag      = 8'($urandom);
      r.offset   = 16'($urandom);
      r.frag_len = 8'($urandom);
      r.fin      = 1'($urandom);
      r.word     = {$urandom, $urandom};
      r.count    = 4'($urandom);
      r.cap      = 8'($urandom);
      return r;
   endfunction

   task automatic queue_clear();
      frag_req_type r;
      r = any_request();
      r.op = OP_CLEAR;
      request_backlog.push_back(r);
   endtask

   task automatic queue_header(input logic [7:0] tag, input logic [15:0] offset,
                               input logic [7:0] frag_len, input logic fin);
      frag_req_type r;
      r = any_request();
      r.op       = OP_HEADER;
      r.tag      = tag;
      r.offset   = offset;
      r.frag_len = frag_len;
      r.fin      = fin;
      request_backlog.push_back(r);
   endtask

   task automatic queue_data(input logic [63:0] word, input logic [3:0] count);
      frag_req_type r;
      r = any_request();
      r.op    = OP_DATA;
      r.word  = word;
      r.count = count;
      request_backlog.push_back(r);
   endtask

   task automatic queue_read(input logic [7:0] tag, input logic [15:0] offset,
                             input logic [7:0] cap);
      frag_req_type r;
      r = any_request();
      r.op     = OP_READ;
      r.tag    = tag;
      r.offset = offset;
      r.cap    = cap;
      request_backlog.push_back(r);
   endtask

   task automatic fill_backlog();
      int start, total, nfrag, len, left, eff, cnt, off, tag;
      logic fin, big, broken, first_big;
      queue_read(8'h00, 16'h0000, 8'd8);
      queue_data({$urandom, $urandom}, 4'd8);
      queue_header(8'h11, 16'd1020, 8'd8, 1'b0);
      queue_header(8'h11, 16'hFFFF, 8'hFF, 1'b1);
      queue_clear();
      queue_header(8'hA5, 16'd0, 8'd10, 1'b0);
      queue_data(64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
      queue_data({$urandom, $urandom}, 4'd15);
      queue_header(8'hA5, 16'd5, 8'd4, 1'b0);
      queue_header(8'h5A, 16'd10, 8'd4, 1'b0);
      queue_header(8'hA5, 16'd10, 8'd0, 1'b0);
      queue_header(8'hA5, 16'd10, 8'd3, 1'b1);
      queue_data({$urandom, $urandom}, 4'd0);
      queue_data({$urandom, $urandom}, 4'd1);
      queue_data(64'h0, 4'd9);
      queue_read(8'hA5, 16'd0, 8'hFF);
      queue_read(8'hA5, 16'd13, 8'hFF);
      queue_read(8'hA5, 16'd14, 8'hFF);
      queue_read(8'h5A, 16'd0, 8'hFF);
      queue_read(8'hA5, 16'd3, 8'd0);
      queue_header(8'hA5, 16'd13, 8'd1, 1'b0);
      queue_data({$urandom, $urandom}, 4'd4);
      queue_header(8'h00, 16'd1024, 8'd0, 1'b0);
      queue_clear();
      start = request_backlog.size();
      first_big = 1'b1;
      while (request_backlog.size() - start < RANDOM_REQUESTS) begin
         if ($urandom_range(0, 5) == 0) begin
            request_backlog.push_back(any_request());
            continue;
         end
         tag   = $urandom_range(0, 255);
         total = 0;
         nfrag = $urandom_range(1, 3);
         if ($urandom_range(0, 3) == 0) queue_clear();
         for (int f = 0; f < nfrag; f++) begin
            big = first_big || ($urandom_range(0, 9) == 0);
            first_big = 1'b0;
            len = big ? $urandom_range(200, 255) : $urandom_range(0, 24);
            fin = (f == nfrag - 1) ? ($urandom_range(0, 7) != 0) : 1'b0;
            broken = ($urandom_range(0, 11) == 0);
            off = (broken && f > 0) ? total + $urandom_range(1, 3) : total;
            queue_header(8'((broken && f == 0) ? tag ^ 1 : tag), 16'(off), 8'(len), fin);
            left = len;
            while (left > 0) begin
               cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
               queue_data({$urandom, $urandom}, 4'(cnt));
               if ($urandom_range(0, 24) == 0) break;
               eff = (cnt > 8) ? 8 : cnt;
               left = left - ((eff > left) ? left : eff);
            end
            total = total + len;
         end
         for (int k = $urandom_range(1, 3); k > 0; k--) begin
            off = ($urandom_range(0, 7) == 0) ? total + $urandom_range(1, 2)
                                              : $urandom_range(0, total);
            queue_read(8'(($urandom_range(0, 9) == 0) ? tag + 1 : tag), 16'(off),
                       8'(($urandom_range(0, 5) == 0) ? 255 : $urandom_range(0, 255)));
         end
      end
   endtask

   function automatic void note_phase(input logic [1:0] p);
      if (cur_phase != p) begin
         cur_phase = p;
         generation = generation + 32'd1;
      end
   endfunction

   function automatic void note_error(input logic [2:0] e);
      if (last_err != e) begin
         last_err = e;
         generation = generation + 32'd1;
      end
   endfunction

   function automatic void close_fragment();
      frag_open = 1'b0;
      stored_len = wr_ptr;
      if (frag_final) begin
         complete = 1'b1;
         note_phase(PH_READY);
      end
      generation = generation + 32'd1;
   endfunction

   function automatic void push_status(input logic ok, input logic [2:0] err,
                                       input logic [63:0] word, input logic [3:0] count,
                                       input logic last);
      blob_status_type s;
      s.ok     = ok;
      s.err    = err;
      s.ph     = cur_phase;
      s.gen    = generation;
      s.stored = stored_len;
      s.done   = complete;
      s.word   = word;
      s.count  = count;
      s.last   = last;
      status_due.push_back(s);
   endfunction

   task automatic stage_request(input frag_req_type rq);
      int unsigned span, pos, n, eff;
      logic [63:0] w;
      case (rq.op)
         OP_CLEAR: begin
            foreach (blob_mem[i]) blob_mem[i] = 8'h00;
            stored_len = '0;
            cur_tag    = '0;
            complete   = 1'b0;
            frag_open  = 1'b0;
            frag_left  = '0;
            frag_final = 1'b0;
            wr_ptr     = '0;
            note_error(ERR_NONE);
            note_phase(PH_EMPTY);
            generation = generation + 32'd1;
            push_status(1'b1, ERR_NONE, '0, '0, 1'b1);
         end
         OP_HEADER: begin
            frag_open = 1'b0;
            if (int'(rq.offset) + int'(rq.frag_len) > BLOB_BYTES_DEF) begin
               note_error(ERR_OVERFLOW);
               push_status(1'b0, ERR_OVERFLOW, '0, '0, 1'b1);
            end else begin
               if (rq.offset == 0) begin
                  cur_tag    = rq.tag;
                  stored_len = '0;
                  complete   = 1'b0;
                  note_error(ERR_NONE);
                  note_phase(PH_RECEIVING);
               end
               if (rq.tag != cur_tag || complete || rq.offset != stored_len) begin
                  note_error(ERR_ORDER);
                  push_status(1'b0, ERR_ORDER, '0, '0, 1'b1);
               end else begin
                  frag_open  = 1'b1;
                  frag_left  = rq.frag_len;
                  frag_final = rq.fin;
                  wr_ptr     = rq.offset;
                  if (rq.frag_len == 0) close_fragment();
                  push_status(1'b1, ERR_NONE, '0, '0, 1'b1);
               end
            end
         end
         OP_DATA: begin
            if (!frag_open) begin
               note_error(ERR_INVALID);
               push_status(1'b0, ERR_INVALID, '0, '0, 1'b1);
            end else begin
               eff = (rq.count > 4'd8) ? 32'd8 : 32'(rq.count);
               for (int i = 0; i < eff && frag_left > 0; i++) begin
                  if (wr_ptr < BLOB_BYTES_DEF) begin
                     blob_mem[MEM_AW'(wr_ptr)] = rq.word[8*i +: 8];
                  end
                  wr_ptr    = wr_ptr + 16'd1;
                  frag_left = frag_left - 8'd1;
               end
               if (frag_left == 0) close_fragment();
               push_status(1'b1, ERR_NONE, '0, '0, 1'b1);
            end
         end
         default: begin
            if (!complete) begin
               note_error(ERR_NO_BLOB);
               push_status(1'b0, ERR_NO_BLOB, '0, '0, 1'b1);
            end else if (rq.tag != cur_tag || rq.offset > stored_len) begin
               note_error(ERR_INVALID);
               push_status(1'b0, ERR_INVALID, '0, '0, 1'b1);
            end else begin
               span = 32'(stored_len) - 32'(rq.offset);
               if (span > 32'(rq.cap)) span = 32'(rq.cap);
               pos = 32'(rq.offset);
               note_error(ERR_NONE);
               do begin
                  n = (span > 32'd8) ? 32'd8 : span;
                  w = '0;
                  for (int i = 0; i < n; i++) w[8*i +: 8] = blob_mem[MEM_AW'(pos + i)];
                  pos  = pos + n;
                  span = span - n;
                  push_status(1'b1, ERR_NONE, w, 4'(n), span == 0);
               end while (span > 0);
            end
         end
      endcase
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         faults++;
      end
   endtask

   always @(posedge clock) begin : drive_requests
      frag_req_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap > 0) begin
            send_gap   <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (request_backlog.size() > 0) begin
            item = request_backlog.pop_front();
            req_tdata  <= {4'b0, item.cap, item.count, item.word, item.frag_len,
                           item.offset, item.tag};
            req_tuser  <= item.op;
            req_tlast  <= item.fin;
            req_tvalid <= 1'b1;
            send_gap   <= pick_gap(0, 40);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : drive_stalls
      int hold;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         hold = pick_gap(1, 30);
         rsp_tready <= (hold == 0);
         if (hold > 0) stall_left <= hold - 1;
      end
   end

   always @(posedge clock) begin : watch_requests
      frag_req_type seen;
      if (!reset && req_tvalid && req_tready) begin
         seen.tag      = req_tdata[7:0];
         seen.offset   = req_tdata[23:8];
         seen.frag_len = req_tdata[31:24];
         seen.word     = req_tdata[95:32];
         seen.count    = req_tdata[99:96];
         seen.cap      = req_tdata[107:100];
         seen.op       = req_tuser;
         seen.fin      = req_tlast;
         stage_request(seen);
         requests_taken++;
      end
   end

   always @(posedge clock) begin : watch_status
      blob_status_type s;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (status_due.size() == 0) begin
            $error("response with no request outstanding: %h", rsp_tdata);
            faults++;
         end else begin
            s = status_due.pop_front();
            check_field("accepted", 64'(s.ok), 64'(rsp_tdata[0]));
            check_field("error_code", 64'(s.err), 64'(rsp_tdata[3:1]));
            check_field("phase", 64'(s.ph), 64'(rsp_tdata[5:4]));
            check_field("generation_count", 64'(s.gen), 64'(rsp_tdata[37:6]));
            check_field("stored_length", 64'(s.stored), 64'(rsp_tdata[53:38]));
            check_field("blob_complete", 64'(s.done), 64'(rsp_tdata[54]));
            check_field("read_word", s.word, rsp_tdata[118:55]);
            check_field("read_count", 64'(s.count), 64'(rsp_tdata[122:119]));
            check_field("last_of_run", 64'(s.last), 64'(rsp_tlast));
         end
      end
   end

   initial begin
      foreach (blob_mem[i]) blob_mem[i] = 8'h00;
      fill_backlog();
      total_requests = request_backlog.size();
      @(posedge clock);
      while (requests_taken < total_requests || status_due.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (faults == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
